@@ hw/rtl/clr_pkg.sv @@
// Shared widths, codes and beat structures of the clipped line rasterizer.
package clr_pkg;

  localparam int COORD_W        = 12;
  localparam int RES_W          = 13;
  localparam int PITCH_W        = 16;
  localparam int BPP_W          = 6;
  localparam int OFF_W          = 28;
  localparam int COLOR_W        = 32;
  localparam int LEFT_W         = 13;
  localparam int ERR_W          = 15;
  localparam int INC_S_W        = 14;
  localparam int BYTES_W        = 3;
  localparam int PROD_X_W       = COORD_W + BYTES_W;
  localparam int MAX_RESOLUTION = 4096;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BPP_W-1:0] BPP_15 = BPP_W'(15);
  localparam logic [BPP_W-1:0] BPP_16 = BPP_W'(16);

  localparam logic [RES_W-1:0]   RESET_X_RES = RES_W'(1024);
  localparam logic [RES_W-1:0]   RESET_Y_RES = RES_W'(768);
  localparam logic [PITCH_W-1:0] RESET_PITCH = PITCH_W'(4096);
  localparam logic [BPP_W-1:0]   RESET_BPP   = BPP_W'(32);

  typedef enum logic [1:0] {
    REG_X_RES = 2'd0,
    REG_Y_RES = 2'd1,
    REG_PITCH = 2'd2,
    REG_BPP   = 2'd3
  } reg_index_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  typedef struct packed {
    logic [RES_W-1:0]   x_res;
    logic [RES_W-1:0]   y_res;
    logic [PITCH_W-1:0] pitch;
    logic [BPP_W-1:0]   bpp;
  } cfg_t;

  // Classified command as it travels from front to back.
  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               y_dir;
    logic               y_major;
    logic [COLOR_W-1:0] color;
  } cmd_t;

endpackage

@@ hw/rtl/clr_ifs.sv @@
// Channel interfaces of the clipped line rasterizer: command, pixel and config.
interface clr_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [clr_pkg::COORD_W-1:0]   x_start;
  logic [clr_pkg::COORD_W-1:0]   y_start;
  logic [clr_pkg::COORD_W-1:0]   x_end;
  logic [clr_pkg::COORD_W-1:0]   y_end;
  logic [clr_pkg::COLOR_W-1:0]   color_word;
  modport source (output valid, mode, x_start, y_start, x_end, y_end, color_word,
                  input ready);
  modport sink (input valid, mode, x_start, y_start, x_end, y_end, color_word,
                output ready);
endinterface

interface clr_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [clr_pkg::COORD_W-1:0]   pixel_x;
  logic [clr_pkg::COORD_W-1:0]   pixel_y;
  logic [clr_pkg::OFF_W-1:0]     byte_offset;
  logic [clr_pkg::COLOR_W-1:0]   pixel_color;
  logic                          visible;
  logic                          last_pixel;
  modport source (output valid, pixel_x, pixel_y, byte_offset, pixel_color, visible,
                  last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, byte_offset, pixel_color, visible,
                last_pixel, output ready);
endinterface

interface clr_cfg_if;
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [31:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/clr_front.sv @@
// Front end: orders the endpoints of a load beat and derives deltas and direction.
module clr_front (
  clr_cmd_if.sink          cmd,
  input  logic             q_full,
  output logic             q_push,
  output clr_pkg::cmd_t    q_data
);

  logic                        swap;
  logic [clr_pkg::COORD_W-1:0] xa, ya, xb, yb;
  logic                        y_dir;
  logic [clr_pkg::COORD_W-1:0] dx, dy;

  // Take a beat whenever the queue has room
  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full;

  // Put the endpoints in order of rising x
  always_comb begin
    swap  = cmd.x_start > cmd.x_end;
    xa    = swap ? cmd.x_end   : cmd.x_start;
    ya    = swap ? cmd.y_end   : cmd.y_start;
    xb    = swap ? cmd.x_start : cmd.x_end;
    yb    = swap ? cmd.y_start : cmd.y_end;
    dx    = xb - xa;
    y_dir = yb < ya;
    dy    = y_dir ? (ya - yb) : (yb - ya);
  end

  // Pack the classified command
  always_comb begin
    q_data.mode    = clr_pkg::mode_t'(cmd.mode);
    q_data.x0      = xa;
    q_data.y0      = ya;
    q_data.dx      = dx;
    q_data.dy      = dy;
    q_data.y_dir   = y_dir;
    q_data.y_major = dy > dx;
    q_data.color   = cmd.color_word;
  end

endmodule

@@ hw/rtl/clr_queue.sv @@
// Short command queue between front and back.
module clr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  clr_pkg::cmd_t   push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output clr_pkg::cmd_t   q_data
);

  clr_pkg::cmd_t                entries [clr_pkg::QUEUE_DEPTH];
  logic [clr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [clr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [clr_pkg::QCNT_W-1:0]   count;

  assign full    = count == clr_pkg::QCNT_W'(clr_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = entries[rd_ptr];

  // Store a pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == clr_pkg::QPTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == clr_pkg::QPTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/clr_back.sv @@
// Back end: line stepping state, address products and pixel output register.
module clr_back (
  input  logic             clk,
  input  logic             rst,
  input  clr_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  clr_pkg::cmd_t    q_data,
  output logic             pop,
  clr_pixel_if.source      pixel
);

  // Line state
  logic [clr_pkg::COORD_W-1:0]        cur_x;
  logic [clr_pkg::COORD_W-1:0]        cur_y;
  logic [clr_pkg::LEFT_W-1:0]         major_left;
  logic signed [clr_pkg::ERR_W-1:0]   error_term;
  logic [clr_pkg::INC_S_W-1:0]        inc_straight;
  logic signed [clr_pkg::ERR_W-1:0]   inc_diagonal;
  logic                               y_direction;
  logic                               y_major;
  logic                               line_active;
  logic [clr_pkg::COLOR_W-1:0]        held_color;

  // Product stage
  logic                               a_valid;
  logic [clr_pkg::COORD_W-1:0]        a_x;
  logic [clr_pkg::COORD_W-1:0]        a_y;
  logic [clr_pkg::COLOR_W-1:0]        a_color;
  logic                               a_vis;
  logic                               a_last;
  logic [clr_pkg::OFF_W-1:0]          a_prod_y;
  logic [clr_pkg::PROD_X_W-1:0]       a_prod_x;

  // Output stage
  logic                               b_valid;

  logic                               a_can;
  logic                               b_can;
  logic                               do_load;
  logic                               do_emit;
  logic                               last;
  logic                               diag;
  logic [clr_pkg::COORD_W-1:0]        y_stepped;
  logic [clr_pkg::COORD_W-1:0]        major;
  logic [clr_pkg::COORD_W-1:0]        minor;
  logic [clr_pkg::BPP_W-1:0]          depth;
  logic [clr_pkg::BYTES_W-1:0]        bytes;
  logic                               vis;

  assign b_can   = !b_valid || pixel.ready;
  assign a_can   = !a_valid || b_can;
  assign pop     = q_valid && a_can;
  assign do_load = pop && (q_data.mode == clr_pkg::MODE_LOAD);
  assign do_emit = pop && (q_data.mode == clr_pkg::MODE_STEP) && line_active;

  // Decode the current pixel and the next step
  always_comb begin
    last      = major_left == '0;
    diag      = error_term > 0;
    y_stepped = y_direction ? (cur_y - 1'b1) : (cur_y + 1'b1);
    major     = q_data.y_major ? q_data.dy : q_data.dx;
    minor     = q_data.y_major ? q_data.dx : q_data.dy;
    depth     = (cfg.bpp == clr_pkg::BPP_15) ? clr_pkg::BPP_16 : cfg.bpp;
    bytes     = depth[clr_pkg::BPP_W-1 -: clr_pkg::BYTES_W];
    vis       = ({1'b0, cur_x} < cfg.x_res) && ({1'b0, cur_y} < cfg.y_res) &&
                (32'(cur_x) < clr_pkg::MAX_RESOLUTION) &&
                (32'(cur_y) < clr_pkg::MAX_RESOLUTION);
  end

  // Load a new line or advance along the major axis
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      major_left   <= '0;
      error_term   <= '0;
      inc_straight <= '0;
      inc_diagonal <= '0;
      y_direction  <= 1'b0;
      y_major      <= 1'b0;
      line_active  <= 1'b0;
      held_color   <= '0;
    end else if (do_load) begin
      cur_x        <= q_data.x0;
      cur_y        <= q_data.y0;
      major_left   <= {1'b0, major};
      error_term   <= $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
      inc_straight <= {1'b0, minor, 1'b0};
      inc_diagonal <= $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
      y_direction  <= q_data.y_dir;
      y_major      <= q_data.y_major;
      line_active  <= 1'b1;
      held_color   <= q_data.color;
    end else if (do_emit) begin
      if (last) begin
        line_active <= 1'b0;
      end else begin
        error_term <= diag ? (error_term + inc_diagonal)
                           : (error_term + $signed({1'b0, inc_straight}));
        if (y_major) begin
          cur_y <= y_stepped;
          if (diag) begin
            cur_x <= cur_x + 1'b1;
          end
        end else begin
          cur_x <= cur_x + 1'b1;
          if (diag) begin
            cur_y <= y_stepped;
          end
        end
        major_left <= major_left - 1'b1;
      end
    end
  end

  // Product stage: form the row and column parts of the address
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_can) begin
      a_valid <= do_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_can && do_emit) begin
      a_x      <= cur_x;
      a_y      <= cur_y;
      a_color  <= held_color;
      a_vis    <= vis;
      a_last   <= last;
      a_prod_y <= cur_y * cfg.pitch;
      a_prod_x <= cur_x * bytes;
    end
  end

  // Output stage: sum the address and hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_can) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_can && a_valid) begin
      pixel.pixel_x     <= a_x;
      pixel.pixel_y     <= a_y;
      pixel.pixel_color <= a_color;
      pixel.visible     <= a_vis;
      pixel.last_pixel  <= a_last;
      pixel.byte_offset <= a_prod_y + clr_pkg::OFF_W'(a_prod_x);
    end
  end

  assign pixel.valid = b_valid;

endmodule

@@ hw/rtl/clipped_line_rasterizer.sv @@
// Top level of the clipped line rasterizer: config registers, front, queue and back.
// A load beat on cmd (mode 0) sets up a line and gives no pixel; each step beat
// (mode 1) of an active line gives one pixel beat, and step beats with no line
// give none. Command beats are taken one per clock while the queue has room, and pixels
// leave one per clock while the sink is ready; a pixel beat passes from the queue to the
// product register and then to the output register, and the product register is there
// for the 12x16 row multiply that has a register stage of its own.
// A two-beat queue between the front and the stepping back end lets either side
// stall alone. Config writes are taken at any time and must only be made while idle.
module clipped_line_rasterizer (
  input  logic          clk,
  input  logic          rst,
  clr_cmd_if.sink       cmd,
  clr_pixel_if.source   pixel,
  clr_cfg_if.sink       cfg
);

  clr_pkg::cfg_t  cfg_regs;
  logic           q_push;
  clr_pkg::cmd_t  q_push_data;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  clr_pkg::cmd_t  q_data;

  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.x_res <= clr_pkg::RESET_X_RES;
      cfg_regs.y_res <= clr_pkg::RESET_Y_RES;
      cfg_regs.pitch <= clr_pkg::RESET_PITCH;
      cfg_regs.bpp   <= clr_pkg::RESET_BPP;
    end else if (cfg.valid) begin
      case (clr_pkg::reg_index_t'(cfg.index))
        clr_pkg::REG_X_RES: cfg_regs.x_res <= cfg.data[clr_pkg::RES_W-1:0];
        clr_pkg::REG_Y_RES: cfg_regs.y_res <= cfg.data[clr_pkg::RES_W-1:0];
        clr_pkg::REG_PITCH: cfg_regs.pitch <= cfg.data[clr_pkg::PITCH_W-1:0];
        clr_pkg::REG_BPP:   cfg_regs.bpp   <= cfg.data[clr_pkg::BPP_W-1:0];
        default:            cfg_regs       <= cfg_regs;
      endcase
    end
  end

  clr_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  clr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  clr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (q_pop),
    .pixel   (pixel)
  );

endmodule

@@ tb/sv/tb_clipped_line_rasterizer.sv @@
// Testbench of the clipped line rasterizer: directed and random line commands, checked per pixel beat.
module tb_clipped_line_rasterizer;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_GAP      = 19;
  localparam int COORD_MAX    = (1 << clr_pkg::COORD_W) - 1;

  typedef struct packed {
    logic [clr_pkg::COORD_W-1:0] x;
    logic [clr_pkg::COORD_W-1:0] y;
    logic [clr_pkg::OFF_W-1:0]   off;
    logic [clr_pkg::COLOR_W-1:0] color;
    logic                        vis;
    logic                        last;
  } pixel_t;

  logic clk;
  logic rst;

  clr_cmd_if   cmd_if ();
  clr_pixel_if pix_if ();
  clr_cfg_if   cfg_if ();

  clipped_line_rasterizer u_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_if),
    .pixel (pix_if),
    .cfg   (cfg_if)
  );

  // Register copy of the line engine
  logic [clr_pkg::RES_W-1:0]   res_x;
  logic [clr_pkg::RES_W-1:0]   res_y;
  logic [clr_pkg::PITCH_W-1:0] pitch_bytes;
  logic [clr_pkg::BPP_W-1:0]   depth_bits;

  // Line state of the line engine
  logic [clr_pkg::COORD_W-1:0] ln_x;
  logic [clr_pkg::COORD_W-1:0] ln_y;
  logic [clr_pkg::LEFT_W-1:0]  ln_left;
  int                          ln_err;
  int                          ln_inc_s;
  int                          ln_inc_d;
  logic                        ln_ydir;
  logic                        ln_ymajor;
  logic                        ln_active;
  logic [clr_pkg::COLOR_W-1:0] ln_color;

  pixel_t pending_pixels[$];
  int     mismatches;
  int     work_items;
  int     cycles;
  bit     src_idle;
  bit     sink_idle;
  int     hold_request;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void reset_line_engine();
    res_x       = clr_pkg::RESET_X_RES;
    res_y       = clr_pkg::RESET_Y_RES;
    pitch_bytes = clr_pkg::RESET_PITCH;
    depth_bits  = clr_pkg::RESET_BPP;
    ln_x        = '0;
    ln_y        = '0;
    ln_left     = '0;
    ln_err      = 0;
    ln_inc_s    = 0;
    ln_inc_d    = 0;
    ln_ydir     = 1'b0;
    ln_ymajor   = 1'b0;
    ln_active   = 1'b0;
    ln_color    = '0;
  endfunction

  function automatic void apply_reg(clr_pkg::reg_index_t idx, logic [31:0] d);
    case (idx)
      clr_pkg::REG_X_RES: res_x = d[clr_pkg::RES_W-1:0];
      clr_pkg::REG_Y_RES: res_y = d[clr_pkg::RES_W-1:0];
      clr_pkg::REG_PITCH: pitch_bytes = d[clr_pkg::PITCH_W-1:0];
      clr_pkg::REG_BPP:   depth_bits = d[clr_pkg::BPP_W-1:0];
      default:   ;
    endcase
  endfunction

  // Order endpoints so x rises, then set up the error terms for the major axis
  function automatic void load_line(logic [clr_pkg::COORD_W-1:0] xa,
                                    logic [clr_pkg::COORD_W-1:0] ya,
                                    logic [clr_pkg::COORD_W-1:0] xb,
                                    logic [clr_pkg::COORD_W-1:0] yb,
                                    logic [clr_pkg::COLOR_W-1:0] col);
    logic [clr_pkg::COORD_W-1:0] t;
    int dx, dy, major, minor;
    if (xa > xb) begin
      t = xa; xa = xb; xb = t;
      t = ya; ya = yb; yb = t;
    end
    dx = int'(xb) - int'(xa);
    if (yb < ya) begin
      dy      = int'(ya) - int'(yb);
      ln_ydir = 1'b1;
    end else begin
      dy      = int'(yb) - int'(ya);
      ln_ydir = 1'b0;
    end
    ln_ymajor = dy > dx;
    major     = ln_ymajor ? dy : dx;
    minor     = ln_ymajor ? dx : dy;
    ln_err    = 2 * minor - major;
    ln_inc_s  = 2 * minor;
    ln_inc_d  = 2 * (minor - major);
    ln_left   = clr_pkg::LEFT_W'(major);
    ln_x      = xa;
    ln_y      = ya;
    ln_color  = col;
    ln_active = 1'b1;
  endfunction

  function automatic logic [clr_pkg::COORD_W-1:0] next_minor_y(
      logic [clr_pkg::COORD_W-1:0] y);
    return ln_ydir ? y - 1'b1 : y + 1'b1;
  endfunction

  // Produce the current pixel of the active line and move along the major axis
  function automatic bit emit_pixel(output pixel_t px);
    int              bytes;
    longint unsigned offs;
    bit              diag;
    px = '0;
    if (!ln_active) return 1'b0;
    bytes    = (depth_bits == clr_pkg::BPP_15) ? int'(clr_pkg::BPP_16) / 8
                                               : int'(depth_bits) / 8;
    offs     = longint'(ln_y) * longint'(pitch_bytes) + longint'(ln_x) * bytes;
    px.x     = ln_x;
    px.y     = ln_y;
    px.off   = offs[clr_pkg::OFF_W-1:0];
    px.color = ln_color;
    px.vis   = (ln_x < res_x) && (ln_y < res_y) &&
               (ln_x < clr_pkg::MAX_RESOLUTION) && (ln_y < clr_pkg::MAX_RESOLUTION);
    px.last  = (ln_left == 0);
    if (px.last) begin
      ln_active = 1'b0;
    end else begin
      // a zero error term takes the straight step
      diag   = ln_err > 0;
      ln_err = ln_err + (diag ? ln_inc_d : ln_inc_s);
      if (ln_ymajor) begin
        ln_y = next_minor_y(ln_y);
        if (diag) ln_x = ln_x + 1'b1;
      end else begin
        ln_x = ln_x + 1'b1;
        if (diag) ln_y = next_minor_y(ln_y);
      end
      ln_left = ln_left - 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compare each pixel beat with the oldest expected pixel
  always @(posedge clk) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (!rst && pix_if.valid && pix_if.ready) begin
      got = {pix_if.pixel_x, pix_if.pixel_y, pix_if.byte_offset, pix_if.pixel_color,
             pix_if.visible, pix_if.last_pixel};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: pixel beat with none expected, got x=%0d y=%0d", $time,
                   got.x, got.y);
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, got.x);
        check_field("pixel_y", want.y, got.y);
        check_field("byte_offset", want.off, got.off);
        check_field("pixel_color", want.color, got.color);
        check_field("visible", want.vis, got.vis);
        check_field("last_pixel", want.last, got.last);
      end
    end
  end

  // Pixel sink: random stalls per beat while sink_idle is set, or a long hold when one is requested
  initial begin : pixel_sink
    int gap;
    pix_if.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        pix_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pix_if.ready <= 1'b1;
      do @(posedge clk); while (!pix_if.valid);
    end
  end

  // Offer one command beat and update the line engine when it is taken
  task automatic send_cmd(clr_pkg::mode_t m, logic [clr_pkg::COORD_W-1:0] xs,
                          logic [clr_pkg::COORD_W-1:0] ys,
                          logic [clr_pkg::COORD_W-1:0] xe,
                          logic [clr_pkg::COORD_W-1:0] ye,
                          logic [clr_pkg::COLOR_W-1:0] col);
    int     gap;
    pixel_t px;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.mode       <= m;
    cmd_if.x_start    <= xs;
    cmd_if.y_start    <= ys;
    cmd_if.x_end      <= xe;
    cmd_if.y_end      <= ye;
    cmd_if.color_word <= col;
    cmd_if.valid      <= 1'b1;
    do @(posedge clk); while (!cmd_if.ready);
    if (m == clr_pkg::MODE_LOAD) begin
      load_line(xs, ys, xe, ye, col);
      work_items++;
    end else if (emit_pixel(px)) begin
      pending_pixels.push_back(px);
      work_items++;
    end
  endtask

  task automatic send_load(int xs, int ys, int xe, int ye,
                           logic [clr_pkg::COLOR_W-1:0] col);
    send_cmd(clr_pkg::MODE_LOAD, clr_pkg::COORD_W'(xs), clr_pkg::COORD_W'(ys),
             clr_pkg::COORD_W'(xe), clr_pkg::COORD_W'(ye), col);
  endtask

  // Step beats carry random endpoint fields, which the block ignores
  task automatic step_line(int n);
    repeat (n)
      send_cmd(clr_pkg::MODE_STEP, clr_pkg::COORD_W'($urandom),
               clr_pkg::COORD_W'($urandom), clr_pkg::COORD_W'($urandom),
               clr_pkg::COORD_W'($urandom), $urandom);
  endtask

  // Drop valid and let every pixel, and any trailing empty step, leave the block
  task automatic drain_pipeline();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(clr_pkg::reg_index_t idx, logic [31:0] value,
                           logic [31:0] mask);
    logic [31:0] d;
    d = ($urandom & ~mask) | (value & mask);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, d);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(int xr, int yr, int pitch, int bpp);
    drain_pipeline();
    write_reg(clr_pkg::REG_X_RES, 32'(xr), 32'h1FFF);
    write_reg(clr_pkg::REG_Y_RES, 32'(yr), 32'h1FFF);
    write_reg(clr_pkg::REG_PITCH, 32'(pitch), 32'hFFFF);
    write_reg(clr_pkg::REG_BPP, 32'(bpp), 32'h3F);
  endtask

  function automatic int pick_end(int base, int span);
    int e;
    e = $urandom_range(0, 1) ? base + $urandom_range(0, span) :
                               base - $urandom_range(0, span);
    if (e < 0) e = 0;
    if (e > COORD_MAX) e = COORD_MAX;
    return e;
  endfunction

  // One line command with random shape, mostly run to its end
  task automatic random_line();
    int xs, ys, xe, ye, span, kind, n, dx, dy;
    kind = $urandom_range(0, 99);
    span = (kind < 85) ? 24 : (kind < 97) ? 300 : COORD_MAX;
    xs   = $urandom_range(0, COORD_MAX);
    ys   = $urandom_range(0, COORD_MAX);
    xe   = pick_end(xs, span);
    ye   = pick_end(ys, span);
    kind = $urandom_range(0, 19);
    if (kind == 0) xe = xs;
    else if (kind == 1) ye = ys;
    else if (kind == 2) begin
      xe = xs;
      ye = ys;
    end
    send_load(xs, ys, xe, ye, $urandom);
    dx = (xe > xs) ? xe - xs : xs - xe;
    dy = (ye > ys) ? ye - ys : ys - ye;
    n  = ((dx > dy) ? dx : dy) + 1;
    // long lines are cut short by the next load
    if (n > 150) n = $urandom_range(20, 150);
    kind = $urandom_range(0, 9);
    if (kind == 0) n = $urandom_range(0, n);
    else if (kind == 1) n = n + $urandom_range(1, 3);
    step_line(n);
  endtask

  task automatic run_lines(int count);
    int target;
    target = work_items + count;
    while (work_items < target) random_line();
  endtask

  task automatic test_step_without_line();
    step_line(1);
  endtask

  task automatic test_single_point();
    send_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
    step_line(2);
  endtask

  task automatic test_vertical_rising();
    send_load(0, 3, 0, 0, 32'h0000_0000);
    step_line(4);
  endtask

  task automatic test_error_tie();
    send_load(0, 0, 2, 1, 32'hA5A5_5A5A);
    step_line(3);
  endtask

  task automatic test_steep_swapped();
    send_load(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 4, 32'h1234_5678);
    step_line(5);
  endtask

  task automatic test_line_replaced();
    send_load(10, 10, 20, 20, 32'hDEAD_BEEF);
    step_line(2);
    send_load(100, 50, 102, 46, 32'h0F0F_F0F0);
    step_line(5);
  endtask

  // Walk through register settings, extremes first, with random lines in each
  task automatic test_config_sweep();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    set_config(0, $urandom_range(0, 8191), $urandom_range(0, 65535), 7);
    run_lines(85);
    set_config(8191, 8191, 65535, 63);
    run_lines(85);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_config(1, 0, 0, 15);
    run_lines(85);
    src_idle = 1'b1;
    set_config(4096, 4096, 4096, 16);
    run_lines(85);
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    set_config(1024, 768, 4096, 8);
    run_lines(85);
    repeat (3) begin
      src_idle  = $urandom_range(0, 1);
      sink_idle = $urandom_range(0, 1);
      set_config($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 65535),
                 $urandom_range(0, 63));
      run_lines(85);
    end
  endtask

  // Hold the sink off while the source keeps stepping, so the block fills up
  task automatic test_sink_backpressure();
    drain_pipeline();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_load(0, 0, COORD_MAX, 1000, $urandom);
    hold_request = 400;
    step_line(60);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    rst               = 1'b1;
    cmd_if.valid      = 1'b0;
    cmd_if.mode       = clr_pkg::MODE_LOAD;
    cmd_if.x_start    = '0;
    cmd_if.y_start    = '0;
    cmd_if.x_end      = '0;
    cmd_if.y_end      = '0;
    cmd_if.color_word = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = clr_pkg::REG_X_RES;
    cfg_if.data       = '0;
    mismatches        = 0;
    work_items        = 0;
    cycles            = 0;
    hold_request      = 0;
    src_idle          = 1'b1;
    sink_idle         = 1'b1;
    reset_line_engine();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_step_without_line();
    test_single_point();
    test_vertical_rising();
    test_error_tie();
    test_steep_swapped();
    test_line_replaced();
    test_sink_backpressure();
    test_config_sweep();

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
